### sv/tla_pkg.sv
// Shared constants, types and codes for the text line assembler.
package tla_pkg;

  localparam int MAX_LINE    = 64;
  localparam int STORE_DEPTH = MAX_LINE - 1;
  localparam int CNT_W       = $clog2(MAX_LINE);
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_BS,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_EVAL
  } back_state_t;

endpackage

### sv/tla_in_if.sv
// Input byte channel.
interface tla_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### sv/tla_out_if.sv
// Output character channel.
interface tla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_end;
  logic       empty_line;

  modport source (output valid, output out_byte, output line_end, output empty_line,
                  input ready);
  modport sink   (input valid, input out_byte, input line_end, input empty_line,
                  output ready);
endinterface

### sv/tla_front.sv
// Front end: accepts input bytes, folds CR-LF pairs and classifies commands.
module tla_front
  import tla_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  tla_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output cmd_t   q_cmd
);

  logic after_cr;
  logic after_cr_next;
  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_cmd.data    = in_ch.in_byte;
    q_cmd.op      = OP_STORE;
    q_push        = accept;
    after_cr_next = after_cr;
    if (accept) begin
      after_cr_next = 1'b0;
      case (in_ch.in_byte)
        CH_LF: begin
          q_cmd.op = OP_END;
          q_push   = !after_cr;
        end
        CH_CR: begin
          q_cmd.op      = OP_END;
          after_cr_next = 1'b1;
        end
        CH_BS:   q_cmd.op = OP_BS;
        default: q_cmd.op = OP_STORE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_cr <= 1'b0;
    end else begin
      after_cr <= after_cr_next;
    end
  end

endmodule

### sv/tla_queue.sv
// Short command queue between front and back.
module tla_queue
  import tla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/tla_back.sv
// Back end: line store, fill count, and line readout into the output register.
module tla_back
  import tla_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  tla_out_if.source  out_ch
);

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_inc;
  logic             pend_valid;
  logic [7:0]       pend_byte;
  back_state_t      state;
  back_state_t      state_next;

  logic             out_valid;
  logic [7:0]       out_byte;
  logic             line_end;
  logic             empty_line;

  logic             can_push;
  logic             term;
  logic             push;
  logic [7:0]       push_byte;
  logic             push_end;
  logic             push_empty;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic             fill_inc;
  logic             fill_dec;
  logic             fill_clr;
  logic             start;
  logic             advance;

  assign can_push = !out_valid || out_ch.ready;
  assign term     = (k == fill) || (rd_data == CH_NUL);
  assign k_inc    = k + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_valid && q_head.op == OP_END && fill != '0) state_next = B_EVAL;
      B_EVAL:  if (term && can_push) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    push       = 1'b0;
    push_byte  = pend_byte;
    push_end   = 1'b0;
    push_empty = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    fill_inc   = 1'b0;
    fill_dec   = 1'b0;
    fill_clr   = 1'b0;
    start      = 1'b0;
    advance    = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            OP_STORE: begin
              q_pop = 1'b1;
              if (fill < CNT_W'(STORE_DEPTH)) begin
                wr_en    = 1'b1;
                fill_inc = 1'b1;
              end
            end
            OP_BS: begin
              q_pop    = 1'b1;
              fill_dec = (fill != '0);
            end
            OP_END: begin
              if (fill == '0) begin
                if (can_push) begin
                  q_pop      = 1'b1;
                  push       = 1'b1;
                  push_byte  = CH_NUL;
                  push_end   = 1'b1;
                  push_empty = 1'b1;
                end
              end else begin
                q_pop = 1'b1;
                rd_en = 1'b1;
                start = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      B_EVAL: begin
        if (term) begin
          if (can_push) begin
            push       = 1'b1;
            push_end   = 1'b1;
            push_empty = !pend_valid;
            push_byte  = pend_valid ? pend_byte : CH_NUL;
            fill_clr   = 1'b1;
          end
        end else if (!pend_valid || can_push) begin
          push    = pend_valid;
          advance = 1'b1;
          rd_en   = (k_inc < fill);
          rd_addr = k_inc[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[IDX_W-1:0]] <= q_head.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k <= '0;
    end else if (advance) begin
      k <= k_inc;
    end
    if (advance) begin
      pend_byte <= rd_data;
    end
    if (push) begin
      out_byte   <= push_byte;
      line_end   <= push_end;
      empty_line <= push_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      fill       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (fill_clr) begin
        fill <= '0;
      end else if (fill_inc) begin
        fill <= fill + 1'b1;
      end else if (fill_dec) begin
        fill <= fill - 1'b1;
      end
      if (start) begin
        pend_valid <= 1'b0;
      end else if (advance) begin
        pend_valid <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_byte;
  assign out_ch.line_end   = line_end;
  assign out_ch.empty_line = empty_line;

endmodule

### sv/text_line_assembler.sv
// Text line assembler: turns a received byte stream into emitted text lines.
//
// in_ch carries one received byte per transaction; out_ch carries one
// character of a completed line per transaction, with line_end on the last
// one and empty_line set (line_end too) for a line with no characters.
// CR, LF and CR-LF each end one line; backspace drops the last stored byte;
// bytes past MAX_LINE-1 are dropped; readout stops at the first zero byte.
// Ordinary bytes and backspace are taken one per cycle while the command
// queue is not full. A line ending is queued when accepted; the back end
// then takes the terminator, starting the first registered store read, and
// reads one stored character per cycle while the output register can take
// it, or emits the empty line directly when nothing is stored. Meanwhile up
// to four further commands are held by the command queue before in_ch
// deasserts ready. The first output of a non-empty line passes a queue
// slot, rd_data, pend_byte and the output register; that of a line with
// nothing stored a queue slot and the output register. Reset clears the
// fill count, the CR flag, the queue and the output valid flag; the line
// store needs no clearing. When the receiver stalls, the output register
// holds and readout pauses, then the queue fills and in_ch stalls in turn.
module text_line_assembler
  import tla_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tla_in_if.sink    in_ch,
  tla_out_if.source out_ch
);

  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  tla_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  tla_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  tla_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### sim/text_line_assembler_tb.sv
`timescale 1ns / 1ps
// Testbench for text_line_assembler: directed and random byte streams checked against a line predictor.
module text_line_assembler_tb;
  import tla_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 32;
  localparam int RAND_ITEMS  = 400;
  localparam int IDLE_PCT    = 32;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } line_char_t;

  logic clk;
  logic rst;

  tla_in_if  in_ch();
  tla_out_if out_ch();

  text_line_assembler u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0]       tx_bytes[$];
  line_char_t       line_chars_q[$];
  logic [7:0]       line_mem[STORE_DEPTH];
  logic [CNT_W-1:0] line_len;
  logic             cr_seen;

  logic in_fire;
  int   sent_cnt;
  int   hold_left;
  logic hold_done;
  int   stall_cnt;
  int   errors;
  logic calm;

  assign calm = (sent_cnt >= 150 && sent_cnt < 260) || (hold_left > 0);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic emit_line();
    int         n;
    int         i;
    line_char_t c;
    n = 0;
    while (n < int'(line_len) && line_mem[n] != CH_NUL) n++;
    line_len = '0;
    if (n == 0) begin
      c.ch    = CH_NUL;
      c.last  = 1'b1;
      c.empty = 1'b1;
      line_chars_q.push_back(c);
    end else begin
      for (i = 0; i < n; i++) begin
        c.ch    = line_mem[i];
        c.last  = (i == n - 1);
        c.empty = 1'b0;
        line_chars_q.push_back(c);
      end
    end
  endtask

  task automatic assemble_byte(input logic [7:0] b);
    if (b == CH_LF) begin
      if (cr_seen) cr_seen = 1'b0;
      else emit_line();
    end else begin
      cr_seen = (b == CH_CR);
      if (cr_seen) begin
        emit_line();
      end else if (b == CH_BS) begin
        if (line_len != '0) line_len = line_len - 1'b1;
      end else if (int'(line_len) < STORE_DEPTH) begin
        line_mem[line_len] = b;
        line_len           = line_len + 1'b1;
      end
    end
  endtask

  // sample both channels, predict and check
  always @(posedge clk) begin
    line_char_t want;
    if (rst) begin
      in_fire   <= 1'b0;
      stall_cnt <= 0;
      line_len  = '0;
      cr_seen   = 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (in_ch.valid && in_ch.ready) assemble_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (line_chars_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected transaction byte=%h end=%b empty=%b", $realtime,
                     out_ch.out_byte, out_ch.line_end, out_ch.empty_line);
        end else begin
          want = line_chars_q.pop_front();
          if (out_ch.line_end !== want.last || out_ch.empty_line !== want.empty ||
              (!want.empty && out_ch.out_byte !== want.ch)) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch exp byte=%h end=%b empty=%b got byte=%h end=%b empty=%b",
                       $realtime, want.ch, want.last, want.empty,
                       out_ch.out_byte, out_ch.line_end, out_ch.empty_line);
          end
        end
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      sent_cnt    <= 0;
    end else begin
      if (in_fire) begin
        void'(tx_bytes.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (in_ch.valid && !in_fire) begin
        // hold the offered byte
      end else if (tx_bytes.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= tx_bytes[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && sent_cnt >= 60) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int         len;
    int         kind;
    int         sel;
    int         k;
    logic       long_line;
    logic [7:0] directed[];
    directed      = '{8'h41, CH_CR, CH_LF, CH_LF, CH_CR, CH_CR, CH_LF,
                      CH_BS, 8'hFF, 8'h7F, 8'h01, CH_BS, CH_CR, CH_LF,
                      CH_NUL, 8'h7A, CH_LF, 8'h61, CH_NUL, 8'h62, CH_CR,
                      8'h80, CH_LF, CH_CR, 8'h71, CH_LF};
    rst           = 1'b1;
    errors        = 0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;

    foreach (directed[i]) tx_bytes.push_back(directed[i]);

    while (tx_bytes.size() < directed.size() + RAND_ITEMS) begin
      kind      = $urandom_range(99);
      long_line = (kind < 8);
      if (kind >= 8 && kind < 12) begin
        len = $urandom_range(6, 1);
        for (k = 0; k < len; k++) tx_bytes.push_back(8'($urandom_range(255)));
      end else begin
        len = long_line ? $urandom_range(90, 66) : $urandom_range(12, 0);
        for (k = 0; k < len; k++) begin
          sel = $urandom_range(99);
          if (sel < 8) tx_bytes.push_back(CH_BS);
          else if (sel < 14 && !long_line) tx_bytes.push_back(8'($urandom_range(255)));
          else tx_bytes.push_back(8'($urandom_range(126, 32)));
        end
        case ($urandom_range(2))
          0: tx_bytes.push_back(CH_CR);
          1: tx_bytes.push_back(CH_LF);
          default: begin
            tx_bytes.push_back(CH_CR);
            tx_bytes.push_back(CH_LF);
          end
        endcase
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!(tx_bytes.size() == 0 && !in_ch.valid && line_chars_q.size() == 0) &&
           stall_cnt < STALL_LIMIT)
      @(negedge clk);

    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("text_line_assembler test failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (line_chars_q.size() != 0)
        $display("%0d expected characters never arrived", line_chars_q.size());
      if (errors == 0 && line_chars_q.size() == 0) begin
        $display("text_line_assembler test passed");
      end else begin
        $display("text_line_assembler test failed");
      end
      $finish;
    end
  end

endmodule
